@@ hw/rtl/h_bridge_break_before_make_defines.svh @@
// ----------------------------------------------------------------------------
// H-bridge break-before-make controller: assertion macros
// Shared property wrappers for the checker that watches the top-level ports.
// ----------------------------------------------------------------------------
`ifndef H_BRIDGE_BREAK_BEFORE_MAKE_DEFINES_SVH
`define H_BRIDGE_BREAK_BEFORE_MAKE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define HBBM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define HBBM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/hbbm_pkg.sv @@
// ----------------------------------------------------------------------------
// H-bridge break-before-make controller package
// Types, codes and the state-to-switch decode shared by the controller files.
// ----------------------------------------------------------------------------
package hbbm_pkg;

    // Width of the dead-time and period counters.
    localparam int TIMER_BITS = 24;
    // Width of the configuration registers and of the write data.
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 2;
    // Comparison width that holds both a counter and a register value.
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [CFG_W-1:0]      DEAD_TIME_RESET = CFG_W'(10000);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OPERATION_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME      = 2'd2;

    // Item kinds.
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_QUEUE = 2'd1;
    localparam logic [1:0] MODE_FORCE = 2'd2;

    // Bridge states.
    localparam logic [1:0] ST_GND   = 2'd0;
    localparam logic [1:0] ST_HVA   = 2'd1;
    localparam logic [1:0] ST_HVB   = 2'd2;
    localparam logic [1:0] ST_HIGHZ = 2'd3;

    // Bit positions in a switch vector.
    localparam int SW_LOW_A  = 0;
    localparam int SW_LOW_B  = 1;
    localparam int SW_HIGH_A = 2;
    localparam int SW_HIGH_B = 3;

    typedef logic [3:0] sw_t;

    typedef struct packed {
        logic                  op_mode;
        logic [CFG_W-1:0]      half_period;
        logic [CFG_W-1:0]      dead_time;
    } cfg_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] req;
        logic       pause;
    } item_t;

    typedef struct packed {
        sw_t                   sw;
        sw_t                   target;
        logic [1:0]            bridge;
        logic                  waiting;
        logic [TIMER_BITS-1:0] dead_cnt;
        logic [TIMER_BITS-1:0] period_cnt;
        logic                  toggle;
        logic                  pend_valid;
        logic [1:0]            pend_state;
    } state_t;

    typedef struct packed {
        sw_t        sw;
        logic [1:0] present_state;
        logic       waiting;
        logic       pulse;
    } result_t;

    // Switch pattern that realizes a bridge state.
    function automatic sw_t pattern_of(input logic [1:0] st);
        sw_t p;
        p = '0;
        case (st)
            ST_GND:   p = sw_t'((1 << SW_LOW_A) | (1 << SW_LOW_B));
            ST_HVA:   p = sw_t'((1 << SW_LOW_B) | (1 << SW_HIGH_A));
            ST_HVB:   p = sw_t'((1 << SW_LOW_A) | (1 << SW_HIGH_B));
            default:  p = '0;
        endcase
        return p;
    endfunction

    localparam state_t STATE_RESET = '{
        sw:         sw_t'((1 << SW_LOW_A) | (1 << SW_LOW_B)),
        target:     sw_t'((1 << SW_LOW_A) | (1 << SW_LOW_B)),
        bridge:     ST_GND,
        waiting:    1'b0,
        dead_cnt:   '0,
        period_cnt: '0,
        toggle:     1'b0,
        pend_valid: 1'b0,
        pend_state: ST_GND
    };

endpackage

@@ hw/rtl/hbbm_step.sv @@
// ----------------------------------------------------------------------------
// H-bridge break-before-make step logic
// Combinational update of the controller state for one transaction.
// ----------------------------------------------------------------------------
module hbbm_step
(
    input  hbbm_pkg::state_t  state_q,
    input  hbbm_pkg::cfg_t    cfg,
    input  hbbm_pkg::item_t   item,
    output hbbm_pkg::state_t  state_d,
    output hbbm_pkg::result_t result
);

    logic                            is_tick;
    logic                            periodic;
    logic                            change;
    logic [1:0]                      change_st;
    logic [hbbm_pkg::TIMER_BITS-1:0] pc_inc;
    logic                            pc_expired;
    logic                            toggle_new;
    logic                            close;
    hbbm_pkg::sw_t                   new_target;

    always_comb
    begin
        state_d    = state_q;
        is_tick    = (item.mode == hbbm_pkg::MODE_TICK);
        periodic   = cfg.op_mode && (cfg.half_period != '0);
        change     = 1'b0;
        change_st  = item.req;
        toggle_new = state_q.toggle ^ 1'b1;
        pc_inc     = (state_q.period_cnt == hbbm_pkg::TIMER_MAX) ?
                     state_q.period_cnt : state_q.period_cnt + 1'b1;
        pc_expired = (hbbm_pkg::CMP_W'(pc_inc) > hbbm_pkg::CMP_W'(cfg.half_period));

        case (item.mode)
            hbbm_pkg::MODE_TICK:
            begin
                if (!periodic)
                begin
                    if (state_q.pend_valid)
                    begin
                        change             = 1'b1;
                        change_st          = state_q.pend_state;
                        state_d.pend_valid = 1'b0;
                    end
                end
                else if (pc_expired && !item.pause)
                begin
                    state_d.period_cnt = '0;
                    state_d.toggle     = toggle_new;
                    change             = 1'b1;
                    change_st          = toggle_new ? hbbm_pkg::ST_HVB : hbbm_pkg::ST_HVA;
                end
                else
                begin
                    state_d.period_cnt = pc_inc;
                end
            end
            hbbm_pkg::MODE_QUEUE:
            begin
                state_d.pend_valid = 1'b1;
                state_d.pend_state = item.req;
            end
            hbbm_pkg::MODE_FORCE:
            begin
                change = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Break: open every switch that the new pattern does not hold.
        new_target = hbbm_pkg::pattern_of(change_st);
        if (change)
        begin
            state_d.target   = new_target;
            state_d.bridge   = change_st;
            state_d.sw       = state_q.sw & new_target;
            state_d.waiting  = 1'b1;
            state_d.dead_cnt = '0;
        end
        else if (is_tick && state_q.waiting)
        begin
            state_d.dead_cnt = (state_q.dead_cnt == hbbm_pkg::TIMER_MAX) ?
                               state_q.dead_cnt : state_q.dead_cnt + 1'b1;
        end

        // Make: close the remaining switches once the dead time has run out.
        close = (change || is_tick) && state_d.waiting &&
                (hbbm_pkg::CMP_W'(state_d.dead_cnt) >= hbbm_pkg::CMP_W'(cfg.dead_time));
        if (close)
        begin
            state_d.sw      = state_d.sw | state_d.target;
            state_d.waiting = 1'b0;
        end

        result.sw            = state_d.sw;
        result.present_state = state_d.bridge;
        result.waiting       = state_d.waiting;
        result.pulse         = change || close;
    end

endmodule

@@ hw/rtl/h_bridge_break_before_make.sv @@
// ----------------------------------------------------------------------------
// H-bridge break-before-make controller
// Sequences four bridge switches with dead time between opening and closing.
// ----------------------------------------------------------------------------
// Usage: each input transaction (in_valid / in_stall) is a tick, a queued
// state request or a forced state. Every input transaction produces exactly
// one output transaction (out_valid / out_stall) that carries the four switch
// drives, the commanded bridge state, the dead-time wait flag and the
// stabilization pulse for the supply monitor.
// Path: an accepted transaction is registered in the input register, then
// processed and registered in the result register, which drives the output.
// Throughput: one transaction per clock while the receiver does not stall; the
// state update is counter increments, compares and a switch decode between the
// input register and the result register.
// Stalls: while the receiver stalls, the result register holds its value and
// the input register holds its transaction; in_stall rises only when both
// are full, so a new transaction is taken while a result waits.
// Reset: the bridge shorts to ground (both low sides on), no request pends,
// the counters clear and the dead time returns to 10000. Configuration writes
// (cfg_we) take effect at once; the user makes them while idle (not enforced).
// ----------------------------------------------------------------------------
module h_bridge_break_before_make
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [hbbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hbbm_pkg::CFG_W-1:0]     cfg_data,
    // Input channel.
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     mode,
    input  logic [1:0]                     requested_state,
    input  logic                           pause,
    // Output channel.
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           low_a_on,
    output logic                           low_b_on,
    output logic                           high_a_on,
    output logic                           high_b_on,
    output logic [1:0]                     present_state,
    output logic                           waiting_dead_time,
    output logic                           stabilize_pulse
);

    // Input register stage.
    logic              in_valid_reg;
    hbbm_pkg::item_t   in_item_reg;
    // Result register stage.
    logic              out_valid_reg;
    hbbm_pkg::result_t out_res_reg;
    // Controller state and configuration.
    hbbm_pkg::state_t  state_reg;
    hbbm_pkg::state_t  state_next;
    hbbm_pkg::cfg_t    cfg_reg;
    hbbm_pkg::cfg_t    cfg_next;

    hbbm_pkg::state_t  step_state;
    hbbm_pkg::result_t step_result;

    logic out_free;
    logic in_take;
    logic proc_fire;

    // The result register can take a new value when it is empty or being read.
    assign out_free  = !out_valid_reg || !out_stall;
    assign proc_fire = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;

    hbbm_step u_step
    (
        .state_q (state_reg),
        .cfg     (cfg_reg),
        .item    (in_item_reg),
        .state_d (step_state),
        .result  (step_result)
    );

    // Next state: the processed transaction first, then any register write.
    // A write to the mode or the half period restarts the period, and a zero
    // half period queues a return to ground.
    always_comb
    begin
        state_next = proc_fire ? step_state : state_reg;
        cfg_next   = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                hbbm_pkg::REG_OPERATION_MODE:
                begin
                    cfg_next.op_mode = cfg_data[0];
                end
                hbbm_pkg::REG_HALF_PERIOD:
                begin
                    cfg_next.half_period = cfg_data;
                end
                hbbm_pkg::REG_DEAD_TIME:
                begin
                    cfg_next.dead_time = cfg_data;
                end
                default:
                begin
                end
            endcase
            if (cfg_index == hbbm_pkg::REG_OPERATION_MODE ||
                cfg_index == hbbm_pkg::REG_HALF_PERIOD)
            begin
                state_next.period_cnt = '0;
                state_next.toggle     = 1'b0;
                if (cfg_next.half_period == '0)
                begin
                    state_next.pend_valid = 1'b1;
                    state_next.pend_state = hbbm_pkg::ST_GND;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= hbbm_pkg::STATE_RESET;
            cfg_reg       <= '{op_mode: 1'b0, half_period: '0,
                               dead_time: hbbm_pkg::DEAD_TIME_RESET};
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            state_reg <= state_next;
            cfg_reg   <= cfg_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= '{mode: mode, req: requested_state, pause: pause};
        end
        if (proc_fire)
        begin
            out_res_reg <= step_result;
        end
    end

    assign out_valid         = out_valid_reg;
    assign low_a_on          = out_res_reg.sw[hbbm_pkg::SW_LOW_A];
    assign low_b_on          = out_res_reg.sw[hbbm_pkg::SW_LOW_B];
    assign high_a_on         = out_res_reg.sw[hbbm_pkg::SW_HIGH_A];
    assign high_b_on         = out_res_reg.sw[hbbm_pkg::SW_HIGH_B];
    assign present_state     = out_res_reg.present_state;
    assign waiting_dead_time = out_res_reg.waiting;
    assign stabilize_pulse   = out_res_reg.pulse;

endmodule

@@ hw/rtl/hbbm_checker.sv @@
// ----------------------------------------------------------------------------
// H-bridge break-before-make port checker
// Watches the top-level ports for shoot-through and sequencing errors.
// ----------------------------------------------------------------------------
`include "h_bridge_break_before_make_defines.svh"

module hbbm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       low_a_on,
    input logic       low_b_on,
    input logic       high_a_on,
    input logic       high_b_on,
    input logic [1:0] present_state,
    input logic       waiting_dead_time,
    input logic       stabilize_pulse
);

    hbbm_pkg::sw_t sw_seen;
    hbbm_pkg::sw_t sw_want;
    logic [7:0]    res_seen;
    logic          settled;
    logic          held;

    assign sw_seen  = {high_b_on, high_a_on, low_b_on, low_a_on};
    assign sw_want  = hbbm_pkg::pattern_of(present_state);
    assign res_seen = {sw_seen, present_state, waiting_dead_time, stabilize_pulse};
    assign settled  = out_valid && !waiting_dead_time;
    assign held     = out_valid && out_stall;

    // Both switches of one leg must never be closed together.
    `HBBM_ASSERT_IMP(a_no_shoot_a, out_valid, !(low_a_on && high_a_on), "leg A shoot-through")
    `HBBM_ASSERT_IMP(a_no_shoot_b, out_valid, !(low_b_on && high_b_on), "leg B shoot-through")

    // Outside a dead-time wait the switches show the commanded state exactly.
    `HBBM_ASSERT_IMP(a_settled_pattern, settled, sw_seen == sw_want, "switches off state pattern")

    // A stalled result stays on the port unchanged.
    `HBBM_ASSERT_NXT(a_stall_hold, held, out_valid && $stable(res_seen), "stalled result changed")

    // The input side only stalls while a result is held back by the receiver.
    `HBBM_ASSERT_IMP(a_in_stall_full, in_stall, out_valid && out_stall, "input stalled while free")

endmodule

bind h_bridge_break_before_make hbbm_checker u_hbbm_checker (.*);
